// ===== sv/sbma_pkg.sv =====
// ----------------------------------------------------------------------------
// sbma_pkg
// Shared widths, constants and the queue entry type of the slope block
// moving-average block.
// ----------------------------------------------------------------------------
package sbma_pkg;

   // Field widths.
   localparam int SAMPLE_W = 10;
   localparam int SLOPE_W  = 10;
   localparam int HW_W     = 3;

   // Window count is at most 2 * 7 + 1 = 15 entries.
   localparam int WIN_W    = 4;

   // A window sum of 15 slopes needs four bits more than one slope.
   localparam int SUM_W    = SLOPE_W + WIN_W;
   localparam int MAG_W    = SUM_W - 1;

   // One quotient bit per divider step.
   localparam int DIV_STEPS = MAG_W;
   localparam int STEP_W    = 4;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Reset value of the window half-width register.
   localparam logic [HW_W-1:0] WIN_HALF_RESET = 3'd2;

   // One classified item: its slope and whether the buffered block must be
   // emitted before the slope is stored.
   typedef struct packed {
      logic signed [SLOPE_W-1:0] slope;
      logic                      flush;
   } q_entry_type;

endpackage

// ===== sv/sbma_ram.sv =====
// ----------------------------------------------------------------------------
// sbma_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbma_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 50
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sbma_front.sv =====
// ----------------------------------------------------------------------------
// sbma_front
// Accepts samples, forms the halved slope and decides whether the item first
// flushes a full block.
// ----------------------------------------------------------------------------
module sbma_front
   import sbma_pkg::*;
#(
   parameter int BLOCK_LEN = 50
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] raw_sample,
   output logic                q_valid,
   input  logic                q_ready,
   output q_entry_type         q_data
);

   localparam int CNT_W = $clog2(BLOCK_LEN + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BLOCK_LEN);

   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                accept;
   logic [SAMPLE_W-1:0] prev_eff;
   logic signed [SAMPLE_W:0] diff;
   logic signed [SAMPLE_W:0] diff_adj;
   logic                full;

   assign req_tready = q_ready;
   assign q_valid    = req_tvalid;
   assign accept     = req_tvalid && q_ready;

   // Slope: a zero previous sample is replaced by the new one; the halving
   // truncates toward zero, so negative differences are rounded up first.
   always_comb begin
      prev_eff = (prev_ff == '0) ? raw_sample : prev_ff;
      diff     = $signed({1'b0, raw_sample}) - $signed({1'b0, prev_eff});
      diff_adj = diff + $signed({{SAMPLE_W{1'b0}}, diff[SAMPLE_W]});
   end

   assign full         = (fill_ff == FULL_COUNT);
   assign q_data.slope = diff_adj[SAMPLE_W:1];
   assign q_data.flush = full;

   // Sample history and fill count.
   always_comb begin
      prev_in = prev_ff;
      fill_in = fill_ff;
      if (accept) begin
         prev_in = raw_sample;
         fill_in = full ? CNT_W'(1) : fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         fill_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== sv/sbma_fifo.sv =====
// ----------------------------------------------------------------------------
// sbma_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module sbma_fifo
   import sbma_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  q_entry_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output q_entry_type out_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW:0] FULL_COUNT = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

   q_entry_type     mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            push;
   logic            pop;

   assign in_ready  = (count_ff != FULL_COUNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (AW + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== sv/sbma_back.sv =====
// ----------------------------------------------------------------------------
// sbma_back
// Stores slopes in the block buffer and, on a flush item, emits the block
// smoothed by a centered moving average before storing the new slope.
// ----------------------------------------------------------------------------
module sbma_back
   import sbma_pkg::*;
#(
   parameter int BLOCK_LEN = 50
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [HW_W-1:0]    win_half,
   input  logic               q_valid,
   output logic               q_ready,
   input  q_entry_type        q_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [SLOPE_W-1:0] rsp_slope,
   output logic               rsp_tlast
);

   localparam int IDX_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
   localparam int POS_W = ((IDX_W > HW_W) ? IDX_W : HW_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_LEN - 1);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_LEN - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SETUP = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_DRAIN = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_WRITE = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [IDX_W-1:0]     hi_ff, hi_in;
   logic [IDX_W-1:0]     wr_idx_ff, wr_idx_in;
   logic [WIN_W-1:0]     cnt_ff, cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [WIN_W-1:0]     rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 out_vld_ff, out_vld_in;
   logic [SLOPE_W-1:0]   out_slope_ff, out_slope_in;
   logic                 out_last_ff, out_last_in;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [SLOPE_W-1:0]   ram_rd_data;
   logic signed [SUM_W-1:0] rd_ext;
   logic signed [SUM_W-1:0] sum_total;
   logic [POS_W-1:0]     pos_i;
   logic [POS_W-1:0]     pos_h;
   logic [POS_W-1:0]     pos_lo;
   logic [POS_W-1:0]     pos_hi_raw;
   logic [POS_W-1:0]     pos_hi;
   logic [POS_W-1:0]     pos_cnt;
   logic [WIN_W:0]       trial;
   logic [WIN_W:0]       cnt_ext;
   logic                 out_free;
   logic [SLOPE_W-1:0]   result;

   // Block buffer.
   sbma_ram #(
      .WIDTH (SLOPE_W),
      .DEPTH (BLOCK_LEN)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (q_data.slope),
      .rd_addr (k_ff),
      .rd_data (ram_rd_data)
   );

   // Window bounds for the current output, clipped to the block.
   always_comb begin
      pos_i      = POS_W'(idx_ff);
      pos_h      = POS_W'(win_half);
      pos_lo     = (pos_i >= pos_h) ? pos_i - pos_h : '0;
      pos_hi_raw = pos_i + pos_h;
      pos_hi     = (pos_hi_raw > LAST_POS) ? LAST_POS : pos_hi_raw;
      pos_cnt    = pos_hi - pos_lo + POS_W'(1);
   end

   // Read data joins the window sum in the cycle after its address.
   assign rd_ext    = {{(SUM_W - SLOPE_W){ram_rd_data[SLOPE_W-1]}}, ram_rd_data};
   assign sum_total = sum_ff + rd_ext;

   // One restoring divider step: shift in the next dividend bit, subtract
   // the window count when it fits.
   assign trial   = {rem_ff, mag_ff[MAG_W-1]};
   assign cnt_ext = {1'b0, cnt_ff};

   // Signed result, truncated toward zero.
   always_comb begin
      if (neg_ff) begin
         result = SLOPE_W'(-mag_ff);
      end else begin
         result = SLOPE_W'(mag_ff);
      end
   end

   assign out_free = !out_vld_ff || rsp_tready;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      hi_in        = hi_ff;
      wr_idx_in    = wr_idx_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      sum_in       = rd_vld_ff ? sum_total : sum_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      out_slope_in = out_slope_ff;
      out_last_in  = out_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_idx_ff;
      q_ready      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_data.flush) begin
                  idx_in   = '0;
                  state_in = ST_SETUP;
               end else begin
                  ram_wr_en = 1'b1;
                  q_ready   = 1'b1;
                  wr_idx_in = wr_idx_ff + IDX_W'(1);
               end
            end
         end
         ST_SETUP: begin
            k_in     = IDX_W'(pos_lo);
            hi_in    = IDX_W'(pos_hi);
            cnt_in   = WIN_W'(pos_cnt);
            sum_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_vld_in = 1'b1;
            k_in      = k_ff + IDX_W'(1);
            if (k_ff == hi_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            neg_in   = sum_total[SUM_W-1];
            mag_in   = sum_total[SUM_W-1] ? MAG_W'(-sum_total) : MAG_W'(sum_total);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial >= cnt_ext) begin
               rem_in = WIN_W'(trial - cnt_ext);
               mag_in = {mag_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in = WIN_W'(trial);
               mag_in = {mag_ff[MAG_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_slope_in = result;
               out_last_in  = (idx_ff == LAST_IDX);
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_WRITE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_SETUP;
               end
            end
         end
         ST_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            q_ready     = 1'b1;
            wr_idx_in   = IDX_W'(1);
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wr_idx_ff  <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_idx_ff  <= wr_idx_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      hi_ff        <= hi_in;
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      mag_ff       <= mag_in;
      rem_ff       <= rem_in;
      neg_ff       <= neg_in;
      step_ff      <= step_in;
      out_slope_ff <= out_slope_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_slope  = out_slope_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/slope_block_moving_average.sv =====
// ----------------------------------------------------------------------------
// slope_block_moving_average
// Turns light-sensor samples into halved slopes, buffers them in blocks and
// emits each full block smoothed by a centered moving average.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one 10-bit sample per item. Slopes are collected in a block
//   buffer of BLOCK_LEN entries. The item that arrives when the buffer is
//   full makes the block emit all BLOCK_LEN smoothed slopes on rsp_*, the
//   last one with rsp_tlast high, before its own slope starts the next block.
//   csr_* writes the window half width (low three bits of csr_data); write
//   it only while no block is being emitted.
// Timing:
//   An item that does not flush passes through the queue and is stored in
//   the block buffer, and a new item can follow every cycle while no block
//   is being emitted. Each smoothed value is formed by a setup step, one
//   buffer read per entry of its clipped window, a drain step, a 13-step
//   shift-subtract divider and an output step that waits for a free result
//   slot. While a block is emitted, the two-entry queue takes one more item;
//   after that req_tready stays low until the block is done.
// Reset and stall:
//   Reset empties the queue, restarts the block at zero fill, clears the
//   previous sample and sets the half width to 2. While rsp_tready is low
//   the held result stays and emission pauses; req_tready drops once the
//   queue is full.
// ----------------------------------------------------------------------------
module slope_block_moving_average
   import sbma_pkg::*;
#(
   parameter int BLOCK_LEN = 50
) (
   input  logic        clock,
   input  logic        reset,
   // Sample channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] raw_sample, [15:10] zero
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] smoothed_slope, [15:10] zero
   output logic        rsp_tlast,   // last_of_block
   // Configuration channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [2:0] win_half, [7:3] ignored
);

   logic [HW_W-1:0]    win_half_ff, win_half_in;
   logic               f_valid;
   logic               f_ready;
   q_entry_type        f_data;
   logic               q_valid;
   logic               q_ready;
   q_entry_type        q_data;
   logic [SLOPE_W-1:0] rsp_slope;

   // Window half-width register.
   assign csr_ready   = 1'b1;
   assign win_half_in = (csr_valid && csr_ready) ? csr_data[HW_W-1:0] : win_half_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_half_ff <= WIN_HALF_RESET;
      end else begin
         win_half_ff <= win_half_in;
      end
   end

   // Front: slope and flush decision.
   sbma_front #(
      .BLOCK_LEN (BLOCK_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .raw_sample (req_tdata[SAMPLE_W-1:0]),
      .q_valid    (f_valid),
      .q_ready    (f_ready),
      .q_data     (f_data)
   );

   // Queue between front and back.
   sbma_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   // Back: buffer and smoothing.
   sbma_back #(
      .BLOCK_LEN (BLOCK_LEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .win_half    (win_half_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_data      (q_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_slope   (rsp_slope),
      .rsp_tlast   (rsp_tlast)
   );

   assign rsp_tdata = {{(16 - SLOPE_W){1'b0}}, rsp_slope};

   // A block only starts while a flush item heads the queue.
   a_emit_on_flush: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (q_valid && q_data.flush))
      else $error("result started without a flush item at the queue head");

   // After the final value of a block is taken, no result follows at once.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("result followed the end of a block immediately");

   // The sample side only stalls when the queue holds items.
   a_stall_needs_queue: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_valid)
      else $error("sample side stalled with an empty queue");

endmodule
